// ===== design/shape_fill_rasterizer_macros.svh =====
// ----------------------------------------------------------------------------
// shape_fill_rasterizer assertion macros
// concurrent checks on the clk / arst_n domain, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef SHAPE_FILL_RASTERIZER_MACROS_SVH
`define SHAPE_FILL_RASTERIZER_MACROS_SVH
`ifndef SYNTH
`define SFR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shape_fill_rasterizer check failed");
`define SFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shape_fill_rasterizer check failed");
`else
`define SFR_ASSERT_SAME(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the shape fill rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	localparam int COLOR_W  = 24;
	localparam int COORD_W  = 9;
	localparam int CANVAS_W = 8;
	localparam int RADIUS_W = 7;
	localparam int COUNT_W  = 16;
	localparam int BND_W    = 11;

	localparam logic [CANVAS_W-1:0] CANVAS_RESET = 8'd128;

	typedef logic signed [BND_W-1:0] bnd_t;

	typedef enum logic [1:0] {
		MODE_CIRCLE = 2'd0,
		MODE_RECT   = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic {
		REG_CANVAS_WIDTH  = 1'b0,
		REG_CANVAS_HEIGHT = 1'b1
	} reg_index_t;

endpackage

`default_nettype wire

// ===== design/shape_fill_rasterizer.sv =====
// ----------------------------------------------------------------------------
// shape_fill_rasterizer
// fills circles and rectangles into a 24-bit frame store, reads pixels back
//
//   channel   signals                                         timing
//   command   start, busy, mode, x/y_first, x/y_second,       taken on start & !busy
//             radius, fill_color
//   result    done, pixel_value, in_bounds, pixels_written    valid one cycle on done
//   config    cfg_we, cfg_index, cfg_data                     written on cfg_we
//
// a draw item scans its bounding box clipped to the canvas (at most 127 by 127
// on the default store) one pixel per cycle, set by the single store write port
// a read item steps through the bounds, base, read and fetch states; an empty
// shape or unused mode goes from the base state straight to report
// after reset the store is cleared one word a cycle, all MAX_WIDTH*MAX_HEIGHT
// words (16384 by default), with busy high
// results cannot be stalled; busy drops in the cycle done is shown
// ----------------------------------------------------------------------------
`default_nettype none

`include "shape_fill_rasterizer_macros.svh"

module shape_fill_rasterizer #(
	parameter int MAX_WIDTH  = sfr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sfr_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [1:0]                           mode,
	input  wire logic signed [sfr_pkg::COORD_W-1:0]   x_first,
	input  wire logic signed [sfr_pkg::COORD_W-1:0]   y_first,
	input  wire logic signed [sfr_pkg::COORD_W-1:0]   x_second,
	input  wire logic signed [sfr_pkg::COORD_W-1:0]   y_second,
	input  wire logic [sfr_pkg::RADIUS_W-1:0]         radius,
	input  wire logic [sfr_pkg::COLOR_W-1:0]          fill_color,
	output logic                                      done,
	output logic [sfr_pkg::COLOR_W-1:0]               pixel_value,
	output logic                                      in_bounds,
	output logic [sfr_pkg::COUNT_W-1:0]               pixels_written,
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_index,
	input  wire logic [sfr_pkg::CANVAS_W-1:0]         cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = 2 * sfr_pkg::CANVAS_W;
	localparam int SQ_W  = 2 * sfr_pkg::RADIUS_W;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_BOUNDS, ST_BASE, ST_SCAN,
		ST_DRAIN, ST_READ, ST_FETCH, ST_REPORT
	} state_t;

	state_t state;

	// configuration
	logic [sfr_pkg::CANVAS_W-1:0] canvas_width_q;
	logic [sfr_pkg::CANVAS_W-1:0] canvas_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= sfr_pkg::CANVAS_RESET;
			canvas_height_q <= sfr_pkg::CANVAS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sfr_pkg::REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data;
				sfr_pkg::REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [sfr_pkg::CANVAS_W-1:0] ew, eh;
	assign ew = (int'(canvas_width_q) > MAX_WIDTH) ? sfr_pkg::CANVAS_W'(MAX_WIDTH)
		: canvas_width_q;
	assign eh = (int'(canvas_height_q) > MAX_HEIGHT) ? sfr_pkg::CANVAS_W'(MAX_HEIGHT)
		: canvas_height_q;

	// captured command
	logic [1:0]                           mode_q;
	logic signed [sfr_pkg::COORD_W-1:0]   x_first_q, y_first_q, x_second_q, y_second_q;
	logic [sfr_pkg::RADIUS_W-1:0]         radius_q;
	logic [sfr_pkg::COLOR_W-1:0]          color_q;

	// clipped bounding box
	sfr_pkg::bnd_t wm2, hm2, cx, cy, sx2, sy2, rad;
	sfr_pkg::bnd_t xa, xb, ya, yb, xlo, xhi, ylo, yhi;

	assign wm2 = $signed({3'b000, ew}) - sfr_pkg::bnd_t'(2);
	assign hm2 = $signed({3'b000, eh}) - sfr_pkg::bnd_t'(2);
	assign cx  = sfr_pkg::bnd_t'(x_first_q);
	assign cy  = sfr_pkg::bnd_t'(y_first_q);
	assign sx2 = sfr_pkg::bnd_t'(x_second_q);
	assign sy2 = sfr_pkg::bnd_t'(y_second_q);
	assign rad = $signed({4'b0000, radius_q});

	always_comb begin
		case (mode_q)
			sfr_pkg::MODE_CIRCLE: begin
				xa = cx - rad;
				xb = cx + rad;
				ya = cy - rad;
				yb = cy + rad;
			end
			sfr_pkg::MODE_RECT: begin
				xa = cx;
				xb = sx2 - sfr_pkg::bnd_t'(1);
				ya = cy;
				yb = sy2;
			end
			sfr_pkg::MODE_READ: begin
				xa = cx;
				xb = cx;
				ya = cy;
				yb = cy;
			end
			default: begin
				xa = sfr_pkg::bnd_t'(1);
				xb = sfr_pkg::bnd_t'(0);
				ya = sfr_pkg::bnd_t'(1);
				yb = sfr_pkg::bnd_t'(0);
			end
		endcase
		xlo = (xa < 0) ? sfr_pkg::bnd_t'(0) : xa;
		ylo = (ya < 0) ? sfr_pkg::bnd_t'(0) : ya;
		xhi = (xb > wm2) ? wm2 : xb;
		yhi = (yb > hm2) ? hm2 : yb;
	end

	logic [sfr_pkg::CANVAS_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q, x_q, y_q;
	logic                         empty_q;
	logic [SQ_W-1:0]              r2_q;
	logic [AW-1:0]                addr_q, row_base_q, clr_q;

	// row start address
	logic [PW-1:0] base_prod;
	assign base_prod = ylo_q * ew;

	// distance terms of the current pixel
	logic signed [sfr_pkg::COORD_W:0]     dx_w, dy_w;
	logic signed [sfr_pkg::CANVAS_W-1:0]  dx8, dy8;
	logic signed [PW-1:0]                 sqx, sqy;

	assign dx_w = $signed({2'b00, x_q}) - $signed({x_first_q[sfr_pkg::COORD_W-1], x_first_q});
	assign dy_w = $signed({2'b00, y_q}) - $signed({y_first_q[sfr_pkg::COORD_W-1], y_first_q});
	assign dx8  = dx_w[sfr_pkg::CANVAS_W-1:0];
	assign dy8  = dy_w[sfr_pkg::CANVAS_W-1:0];
	assign sqx  = dx8 * dx8;
	assign sqy  = dy8 * dy8;

	// write stage
	logic                valid_s1;
	logic [AW-1:0]       addr_s1;
	logic [SQ_W-1:0]     sqx_s1, sqy_s1;
	logic [SQ_W:0]       dist_s1;
	logic                hit_s1;
	logic [sfr_pkg::COUNT_W-1:0] count_q;

	assign dist_s1 = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign hit_s1  = valid_s1 && ((mode_q == sfr_pkg::MODE_RECT) || (dist_s1 < {1'b0, r2_q}));

	// frame store
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [sfr_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;

	assign ram_we    = (state == ST_CLEAR) || hit_s1;
	assign ram_waddr = (state == ST_CLEAR) ? clr_q : addr_s1;
	assign ram_wdata = (state == ST_CLEAR) ? '0 : color_q;

	sfr_ram #(
		.WIDTH (sfr_pkg::COLOR_W),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	logic done_q, in_bounds_q;
	logic [sfr_pkg::COLOR_W-1:0] pixel_value_q;
	logic [sfr_pkg::COUNT_W-1:0] pixels_written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state            <= ST_CLEAR;
			clr_q            <= '0;
			valid_s1         <= 1'b0;
			count_q          <= '0;
			done_q           <= 1'b0;
			in_bounds_q      <= 1'b0;
			pixel_value_q    <= '0;
			pixels_written_q <= '0;
			mode_q           <= sfr_pkg::MODE_NONE;
			empty_q          <= 1'b1;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= 1'b0;
			if (hit_s1 && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
			case (state)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						mode_q     <= mode;
						x_first_q  <= x_first;
						y_first_q  <= y_first;
						x_second_q <= x_second;
						y_second_q <= y_second;
						radius_q   <= radius;
						color_q    <= fill_color;
						count_q    <= '0;
						state      <= ST_BOUNDS;
					end
				end
				ST_BOUNDS: begin
					xlo_q   <= xlo[sfr_pkg::CANVAS_W-1:0];
					xhi_q   <= xhi[sfr_pkg::CANVAS_W-1:0];
					ylo_q   <= ylo[sfr_pkg::CANVAS_W-1:0];
					yhi_q   <= yhi[sfr_pkg::CANVAS_W-1:0];
					empty_q <= (xhi < xlo) || (yhi < ylo);
					r2_q    <= radius_q * radius_q;
					state   <= ST_BASE;
				end
				ST_BASE: begin
					addr_q     <= AW'(base_prod) + AW'(xlo_q);
					row_base_q <= AW'(base_prod);
					x_q        <= xlo_q;
					y_q        <= ylo_q;
					if (empty_q) begin
						state <= ST_REPORT;
					end else if (mode_q == sfr_pkg::MODE_READ) begin
						state <= ST_READ;
					end else begin
						state <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					valid_s1 <= 1'b1;
					addr_s1  <= addr_q;
					sqx_s1   <= sqx[SQ_W-1:0];
					sqy_s1   <= sqy[SQ_W-1:0];
					if (x_q == xhi_q) begin
						x_q <= xlo_q;
						if (y_q == yhi_q) begin
							state <= ST_DRAIN;
						end else begin
							y_q        <= y_q + 1'b1;
							row_base_q <= row_base_q + AW'(ew);
							addr_q     <= row_base_q + AW'(ew) + AW'(xlo_q);
						end
					end else begin
						x_q    <= x_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state <= ST_REPORT;
				end
				ST_READ: begin
					state <= ST_FETCH;
				end
				ST_FETCH: begin
					done_q           <= 1'b1;
					pixel_value_q    <= ram_rdata;
					in_bounds_q      <= 1'b1;
					pixels_written_q <= '0;
					state            <= ST_IDLE;
				end
				ST_REPORT: begin
					done_q           <= 1'b1;
					pixel_value_q    <= '0;
					in_bounds_q      <= 1'b0;
					pixels_written_q <= count_q;
					state            <= ST_IDLE;
				end
				default: begin
					state <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state != ST_IDLE);
	assign done           = done_q;
	assign pixel_value    = pixel_value_q;
	assign in_bounds      = in_bounds_q;
	assign pixels_written = pixels_written_q;

	`SFR_ASSERT_SAME(a_done_not_busy, done, !busy)
	`SFR_ASSERT_SAME(a_read_or_draw, done, (pixels_written == '0) || !in_bounds)
	`SFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`SFR_ASSERT_SAME(a_clear_no_result, state == ST_CLEAR, !done && !hit_s1)

endmodule

`default_nettype wire

// ===== design/sfr_ram.sv =====
// ----------------------------------------------------------------------------
// sfr_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
